// ===== rtl/core/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator package
// Screen geometry, field widths, pixel and step types, shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 64;
    localparam int MAX_RESULTS    = 64;

    localparam int SPAN_MAX   = (SCREEN_COLUMNS > SCREEN_ROWS) ? SCREEN_COLUMNS : SCREEN_ROWS;
    localparam int COORD_W    = $clog2(SPAN_MAX);
    localparam int ERR_W      = COORD_W + 3;
    localparam int MAX_PIXELS = 2 * MAX_RESULTS;
    localparam int LEFT_W     = $clog2(MAX_PIXELS + 1);

    localparam int IN_X_W    = 8;
    localparam int IN_Y_W    = 7;
    localparam int COL_W     = 7;
    localparam int PAGE_W    = 3;
    localparam int MASK_W    = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef logic [COORD_W-1:0] t_coord;

    // column in the lowest bits
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [PAGE_W-1:0] page;
        logic [COL_W-1:0]  column;
    } t_pixel;

    localparam int PIX_W = $bits(t_pixel);

    typedef struct packed {
        t_coord                  minor;
        logic signed [ERR_W-1:0] err;
    } t_step;

    // 1-based coordinate to 0-based, clamped to 0..hi-1
    function automatic t_coord f_clamp(input logic [IN_X_W-1:0] v, input int hi);
        int vi;
        vi = int'(v);
        if (vi < 1) begin
            return '0;
        end else if (vi > hi) begin
            return COORD_W'(hi - 1);
        end
        return COORD_W'(vi - 1);
    endfunction

    function automatic t_pixel f_pixel(input t_coord col, input t_coord row);
        t_pixel p;
        p.column = COL_W'(int'(col));
        p.page   = PAGE_W'(int'(row) >> 3);
        p.mask   = MASK_W'(1) << row[2:0];
        return p;
    endfunction

    // one Bresenham error step
    function automatic t_step f_step(input t_coord minor, input logic signed [ERR_W-1:0] err,
                                     input t_coord dmaj, input t_coord dmin,
                                     input logic dir_down);
        t_step                   s;
        logic signed [ERR_W-1:0] e;
        logic signed [ERR_W-1:0] maj_s;
        e     = err + $signed(ERR_W'(dmin));
        maj_s = $signed(ERR_W'(dmaj));
        s.minor = minor;
        s.err   = e;
        if ((e <<< 1) >= maj_s) begin
            s.minor = dir_down ? t_coord'(minor - 1'b1) : t_coord'(minor + 1'b1);
            s.err   = e - maj_s;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/line_pixel_generator_top.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator
// Bresenham line rasteriser for a page-organised monochrome display.
//
// Input channel (s_axis): one item is a line request with two 1-based
// endpoints; coordinates are clamped to the screen and made 0-based.
// Output channel (m_axis): each item carries up to two pixels as column,
// page and one-hot mask; tuser flags the second pixel, tlast ends the line.
//
// An accepted request is clamped as it is captured, then goes to setup (steep
// test, axis swap, ordering), and the two-step error unit then produces one
// output item per cycle while the receiver accepts. s_axis_tready is high
// only while idle; the next request is taken once the final item of the line
// sits in the output register. A stalled receiver holds the output register
// and the walk. Reset returns to idle and drops any output item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_generator_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // start_x[7:0], start_y[14:8], end_x[22:15], end_y[29:23], zero[31:30]
    input  wire logic [lpg_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // first_column[6:0], first_page[9:7], first_mask[17:10],
    // second_column[24:18], second_page[27:25], second_mask[35:28], zero[39:36]
    output logic [lpg_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // second_valid[0]
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } t_state;

    t_state r_state;

    lpg_pkg::t_coord r_ax, r_ay, r_bx, r_by;
    lpg_pkg::t_coord r_major, r_minor, r_dmaj, r_dmin;
    logic signed [lpg_pkg::ERR_W-1:0] r_err;
    logic r_steep, r_dir_down;
    logic [lpg_pkg::LEFT_W-1:0] r_left;

    logic                                r_out_valid;
    logic [lpg_pkg::M_TDATA_W-1:0]       r_out_data;
    logic                                r_out_user;
    logic                                r_out_last;

    // setup
    lpg_pkg::t_coord dx, dy, a_maj, a_min, b_maj, b_min;
    lpg_pkg::t_coord s_maj, s_min, e_maj, e_min, su_dmaj, su_dmin;
    logic            su_steep, su_swap, su_dir;
    logic [lpg_pkg::COORD_W:0]  su_pixels;
    logic [lpg_pkg::LEFT_W-1:0] su_left;

    always_comb begin
        dx       = (r_bx >= r_ax) ? lpg_pkg::t_coord'(r_bx - r_ax)
                                  : lpg_pkg::t_coord'(r_ax - r_bx);
        dy       = (r_by >= r_ay) ? lpg_pkg::t_coord'(r_by - r_ay)
                                  : lpg_pkg::t_coord'(r_ay - r_by);
        su_steep = dy > dx;
        a_maj    = su_steep ? r_ay : r_ax;
        a_min    = su_steep ? r_ax : r_ay;
        b_maj    = su_steep ? r_by : r_bx;
        b_min    = su_steep ? r_bx : r_by;
        su_swap  = a_maj > b_maj;
        s_maj    = su_swap ? b_maj : a_maj;
        s_min    = su_swap ? b_min : a_min;
        e_maj    = su_swap ? a_maj : b_maj;
        e_min    = su_swap ? a_min : b_min;
        su_dmaj  = lpg_pkg::t_coord'(e_maj - s_maj);
        su_dmin  = (e_min >= s_min) ? lpg_pkg::t_coord'(e_min - s_min)
                                    : lpg_pkg::t_coord'(s_min - e_min);
        su_dir   = s_min > e_min;
        su_pixels = {1'b0, su_dmaj} + 1'b1;
        su_left  = (int'(su_pixels) > lpg_pkg::MAX_PIXELS)
                   ? lpg_pkg::LEFT_W'(lpg_pkg::MAX_PIXELS)
                   : lpg_pkg::LEFT_W'(su_pixels);
    end

    // walk: two error steps per cycle while the output slot is free
    lpg_pkg::t_step  step1, step2;
    lpg_pkg::t_coord major1;
    lpg_pkg::t_pixel pix0, pix1;
    logic            has2, is_last, slot_free;

    always_comb begin
        major1    = lpg_pkg::t_coord'(r_major + 1'b1);
        step1     = lpg_pkg::f_step(r_minor, r_err, r_dmaj, r_dmin, r_dir_down);
        step2     = lpg_pkg::f_step(step1.minor, step1.err, r_dmaj, r_dmin, r_dir_down);
        pix0      = r_steep ? lpg_pkg::f_pixel(r_minor, r_major)
                            : lpg_pkg::f_pixel(r_major, r_minor);
        pix1      = r_steep ? lpg_pkg::f_pixel(step1.minor, major1)
                            : lpg_pkg::f_pixel(major1, step1.minor);
        has2      = r_left >= lpg_pkg::LEFT_W'(2);
        is_last   = r_left <= lpg_pkg::LEFT_W'(2);
        slot_free = !r_out_valid || i_m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // while walking, a free slot is always refilled below
            if (r_out_valid && i_m_axis_tready && (r_state != ST_WALK)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_ax    <= lpg_pkg::f_clamp(i_s_axis_tdata[7:0],
                                                    lpg_pkg::SCREEN_COLUMNS);
                        r_ay    <= lpg_pkg::f_clamp({1'b0, i_s_axis_tdata[14:8]},
                                                    lpg_pkg::SCREEN_ROWS);
                        r_bx    <= lpg_pkg::f_clamp(i_s_axis_tdata[22:15],
                                                    lpg_pkg::SCREEN_COLUMNS);
                        r_by    <= lpg_pkg::f_clamp({1'b0, i_s_axis_tdata[29:23]},
                                                    lpg_pkg::SCREEN_ROWS);
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_steep    <= su_steep;
                    r_major    <= s_maj;
                    r_minor    <= s_min;
                    r_dmaj     <= su_dmaj;
                    r_dmin     <= su_dmin;
                    r_dir_down <= su_dir;
                    r_err      <= '0;
                    r_left     <= su_left;
                    r_state    <= ST_WALK;
                end
                ST_WALK: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= has2;
                        r_out_last  <= is_last;
                        r_out_data  <= {{(lpg_pkg::M_TDATA_W - 2 * lpg_pkg::PIX_W){1'b0}},
                                        (has2 ? pix1 : lpg_pkg::t_pixel'('0)), pix0};
                        r_major     <= lpg_pkg::t_coord'(r_major + 2'd2);
                        r_minor     <= step2.minor;
                        r_err       <= step2.err;
                        r_left      <= has2 ? lpg_pkg::LEFT_W'(r_left - 2'd2)
                                            : lpg_pkg::LEFT_W'(r_left - 1'b1);
                        if (is_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request accepted while a line is in progress");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("single-pixel item before end of line");

    a_absent_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[35:18] == '0)
        else $error("absent second pixel not zero");

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot(o_m_axis_tdata[17:10]))
        else $error("first pixel mask not one-hot");

endmodule

`default_nettype wire
